FILE: sv/gml_pkg.sv
// shared types, codes and table helpers for the gaussian membership learner
`default_nettype none

package gml_pkg;

   // request kinds
   localparam logic [2:0] REQ_EVAL    = 3'd0;
   localparam logic [2:0] REQ_ACC     = 3'd1;
   localparam logic [2:0] REQ_UPDATE  = 3'd2;
   localparam logic [2:0] REQ_RESTORE = 3'd3;
   localparam logic [2:0] REQ_CLEAR   = 3'd4;

   // register indexes
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_INIT_MEAN  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INIT_WIDTH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEARN_RATE = 2'd2;

   // divider geometry
   localparam int DIV_NUM_W = 96;
   localparam int DIV_DEN_W = 62;
   localparam int DIV_Q_W   = 63;
   localparam logic [DIV_Q_W-1:0] DIV_CAP = 63'h1 << 62;

   // datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
   localparam logic [OP_W-1:0] OP_PREP   = 4'd2;
   localparam logic [OP_W-1:0] OP_SQ     = 4'd3;
   localparam logic [OP_W-1:0] OP_LUT    = 4'd4;
   localparam logic [OP_W-1:0] OP_INTERP = 4'd5;
   localparam logic [OP_W-1:0] OP_ROUND  = 4'd6;
   localparam logic [OP_W-1:0] OP_NUMC   = 4'd7;
   localparam logic [OP_W-1:0] OP_SPLIT  = 4'd8;
   localparam logic [OP_W-1:0] OP_CAT    = 4'd9;
   localparam logic [OP_W-1:0] OP_UPMUL  = 4'd10;
   localparam logic [OP_W-1:0] OP_FIN    = 4'd11;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            div_start;
      logic            emit;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       spread_pos;
   } stat_type;

   typedef struct packed {
      logic [16:0] membership;
      logic [31:0] grad_center;
      logic [31:0] grad_spread;
      logic [31:0] cur_center;
      logic [31:0] cur_spread;
      logic        status;
   } res_type;

   // integer quotient by shift and subtract, for table constants only
   function automatic logic [63:0] const_quot(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         if (r >= b) begin
            r    = r - b;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // per-step factor exp(-h) in Q0.30 from a truncated series
   function automatic logic [63:0] exp_base(input logic [63:0] h);
      logic [63:0] term;
      longint      b;
      term = 64'd1 << 30;
      b    = longint'(64'd1 << 30);
      for (int n = 1; n <= 24; n++) begin
         term = const_quot((term * h) >> 30, 64'(n));
         if ((n & 1) != 0) b = b - longint'(term);
         else b = b + longint'(term);
      end
      if (b < 0) b = 0;
      return 64'(b);
   endfunction

   // table entry k: repeated rounded products of the step factor
   function automatic logic [30:0] exp_entry(input logic [63:0] b, input int k);
      logic [63:0] e;
      e = 64'd1 << 30;
      for (int i = 1; i <= k; i++) e = (e * b + (64'd1 << 29)) >> 30;
      return 31'(e);
   endfunction

endpackage

`default_nettype wire

FILE: sv/gml_div.sv
// radix-2 restoring divider, quotient capped at 2^62
`default_nettype none

module gml_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [gml_pkg::DIV_NUM_W-1:0] num,
   input  wire logic [gml_pkg::DIV_DEN_W-1:0] den,
   output logic      [gml_pkg::DIV_Q_W-1:0]   quo,
   output logic                               done
);
   import gml_pkg::*;

   localparam int HI_W  = DIV_NUM_W - DIV_Q_W;
   localparam int CNT_W = $clog2(DIV_Q_W);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in, den_ff;
   logic [DIV_Q_W-1:0]   work_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 run_ff, done_ff;
   logic [HI_W-1:0]      hi;
   logic                 ovf;
   logic [DIV_DEN_W:0]   trial, trial_sub;
   logic                 ge;

   always_comb begin
      hi        = num[DIV_NUM_W-1:DIV_Q_W];
      ovf       = DIV_DEN_W'(hi) >= den;
      trial     = {rem_ff, work_ff[DIV_Q_W-1]};
      ge        = trial >= {1'b0, den_ff};
      trial_sub = trial - {1'b0, den_ff};
      rem_in    = ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            den_ff <= den;
            cnt_ff <= '0;
            if (ovf) begin
               work_ff <= DIV_CAP;
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               rem_ff  <= DIV_DEN_W'(hi);
               work_ff <= num[DIV_Q_W-1:0];
               run_ff  <= 1'b1;
            end
         end else if (run_ff) begin
            rem_ff  <= rem_in;
            work_ff <= {work_ff[DIV_Q_W-2:0], ge};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_Q_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quo  = (work_ff > DIV_CAP) ? DIV_CAP : work_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

FILE: sv/gml_ctrl.sv
// request sequencer for the gaussian membership learner
`default_nettype none

module gml_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire gml_pkg::stat_type stat,
   input  wire logic              div_done,
   input  wire logic              out_free,
   output gml_pkg::cmd_type       cmd
);
   import gml_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DISP   = 5'd1;
   localparam logic [4:0] S_PREP   = 5'd2;
   localparam logic [4:0] S_DIVR   = 5'd3;
   localparam logic [4:0] S_WAITR  = 5'd4;
   localparam logic [4:0] S_SQ     = 5'd5;
   localparam logic [4:0] S_LUT    = 5'd6;
   localparam logic [4:0] S_INTERP = 5'd7;
   localparam logic [4:0] S_ROUND  = 5'd8;
   localparam logic [4:0] S_NUMC   = 5'd9;
   localparam logic [4:0] S_DIVC   = 5'd10;
   localparam logic [4:0] S_WAITC  = 5'd11;
   localparam logic [4:0] S_SPLIT  = 5'd12;
   localparam logic [4:0] S_CAT    = 5'd13;
   localparam logic [4:0] S_DIVS   = 5'd14;
   localparam logic [4:0] S_WAITS  = 5'd15;
   localparam logic [4:0] S_UPMUL  = 5'd16;
   localparam logic [4:0] S_FIN    = 5'd17;

   logic [4:0] state_ff, state_in;
   logic       is_calc;

   assign is_calc = (stat.kind == REQ_EVAL) || (stat.kind == REQ_ACC);

   always_comb begin
      state_in      = state_ff;
      cmd.op        = OP_NONE;
      cmd.div_start = 1'b0;
      cmd.emit      = 1'b0;
      req_ready     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (is_calc && stat.spread_pos) state_in = S_PREP;
            else if (stat.kind == REQ_UPDATE) state_in = S_UPMUL;
            else state_in = S_FIN;
         end
         S_PREP: begin
            cmd.op   = OP_PREP;
            state_in = (stat.kind == REQ_EVAL) ? S_DIVR : S_NUMC;
         end
         S_DIVR: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAITR;
         end
         S_WAITR: if (div_done) state_in = S_SQ;
         S_SQ: begin
            cmd.op   = OP_SQ;
            state_in = S_LUT;
         end
         S_LUT: begin
            cmd.op   = OP_LUT;
            state_in = S_INTERP;
         end
         S_INTERP: begin
            cmd.op   = OP_INTERP;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.op   = OP_ROUND;
            state_in = S_NUMC;
         end
         S_NUMC: begin
            cmd.op   = OP_NUMC;
            state_in = S_DIVC;
         end
         S_DIVC: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAITC;
         end
         S_WAITC: if (div_done) state_in = S_SPLIT;
         S_SPLIT: begin
            cmd.op   = OP_SPLIT;
            state_in = S_CAT;
         end
         S_CAT: begin
            cmd.op   = OP_CAT;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAITS;
         end
         S_WAITS: if (div_done) state_in = S_FIN;
         S_UPMUL: begin
            cmd.op   = OP_UPMUL;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.op   = OP_FIN;
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

FILE: sv/gml_dp.sv
// datapath: registers, state, exp table and arithmetic steps
`default_nettype none

module gml_dp #(
   parameter int FRAC_BITS       = 16,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wen,
   input  wire logic [gml_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [31:0]                    csr_wdata,
   input  wire logic [2:0]                     req_kind,
   input  wire logic [31:0]                    sample,
   input  wire logic [31:0]                    error_grad,
   input  wire gml_pkg::cmd_type               cmd,
   output gml_pkg::stat_type                   stat,
   output logic [gml_pkg::DIV_NUM_W-1:0]       div_num,
   output logic [gml_pkg::DIV_DEN_W-1:0]       div_den,
   input  wire logic [gml_pkg::DIV_Q_W-1:0]    div_quo,
   output gml_pkg::res_type                    res
);
   import gml_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int D      = EXP_TABLE_DEPTH;
   localparam int R_W    = F + 3;
   localparam int RSQ_W  = 2 * R_W;
   localparam int A_W    = RSQ_W - (F + 1);
   localparam int TI_W   = $clog2(D + 1);
   localparam int POS_W  = A_W + TI_W;
   localparam int FR_W   = F + 4;
   localparam int IDXF_W = POS_W - FR_W;
   localparam int M_W    = F + 1;
   localparam int PROD_W = 31 + FR_W;
   localparam int MAD_W  = M_W + 33;
   localparam logic [DIV_Q_W-1:0] R_LIMIT   = 63'd8 << F;
   localparam logic [31:0]        ROUND_ADD = 32'd1 << (29 - F);
   localparam logic [63:0]        EXP_H     = (64'd16 << 30) / EXP_TABLE_DEPTH;
   localparam logic [63:0]        EXP_B     = exp_base(EXP_H);

   // constant exp table
   logic [30:0] etab [0:D];
   for (genvar k = 0; k <= D; k++) begin : g_etab
      localparam logic [30:0] ENTRY = exp_entry(EXP_B, k);
      assign etab[k] = ENTRY;
   end

   // configuration and architectural state
   logic [31:0] init_mean_ff, init_width_ff;
   logic [15:0] learn_rate_ff;
   logic [31:0] center_ff, spread_ff, center_in, spread_in;
   logic [47:0] sumc_ff, sums_ff, sumc_in, sums_in;

   // per-request working registers
   logic [2:0]           kind_ff;
   logic                 d_neg_ff, e_neg_ff;
   logic [32:0]          ad_ff;
   logic [31:0]          ae_ff;
   logic [61:0]          ssq_ff;
   logic [64:0]          eprod_ff, plo_ff;
   logic [63:0]          phi_ff, dc_ff, ds_ff;
   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [RSQ_W-1:0]     rsq_ff;
   logic                 rbig_ff, mzero_ff;
   logic [30:0]          e0_ff, diff_ff;
   logic [FR_W-1:0]      fr_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [M_W-1:0]       m_ff;
   logic [DIV_Q_W-1:0]   mc_ff;

   logic        spread_pos;
   logic [30:0] s;
   logic [32:0] d;
   logic [47:0] sumc_mag, sums_mag;

   assign spread_pos = !spread_ff[31] && (spread_ff != 32'd0);
   assign s          = spread_ff[30:0];
   assign d          = {sample[31], sample} - {center_ff[31], center_ff};
   assign sumc_mag   = sumc_ff[47] ? (48'd0 - sumc_ff) : sumc_ff;
   assign sums_mag   = sums_ff[47] ? (48'd0 - sums_ff) : sums_ff;

   // table lookup
   logic [A_W-1:0]    lut_a;
   logic [POS_W-1:0]  lut_pos;
   logic [IDXF_W-1:0] lut_idxf;
   logic              lut_zero;
   logic [TI_W-1:0]   lut_idx, lut_idx1;
   logic [30:0]       lut_v;
   logic [31:0]       lut_vr;
   logic [MAD_W-1:0]  mad;

   always_comb begin
      lut_a    = rsq_ff[RSQ_W-1:F+1];
      lut_pos  = POS_W'(lut_a) * POS_W'(D);
      lut_idxf = lut_pos[POS_W-1:FR_W];
      lut_zero = rbig_ff || (lut_idxf >= IDXF_W'(D));
      lut_idx  = lut_zero ? '0 : lut_idxf[TI_W-1:0];
      lut_idx1 = lut_idx + 1'b1;
      lut_v    = e0_ff - 31'(prod_ff >> FR_W);
      lut_vr   = {1'b0, lut_v} + ROUND_ADD;
      mad      = MAD_W'(m_ff) * MAD_W'(ad_ff);
   end

   function automatic logic [31:0] sat32(input logic [49:0] v);
      if (!v[49] && (v[48:31] != '0)) return 32'h7fff_ffff;
      else if (v[49] && (v[48:31] != '1)) return 32'h8000_0000;
      else return v[31:0];
   endfunction

   function automatic logic [47:0] sat48(input logic [49:0] v);
      if (!v[49] && (v[48:47] != 2'b00)) return 48'h7fff_ffff_ffff;
      else if (v[49] && (v[48:47] != 2'b11)) return 48'h8000_0000_0000;
      else return v[47:0];
   endfunction

   function automatic logic [47:0] add48(input logic [47:0] sum,
                                         input logic [62:0] m, input logic neg);
      logic [48:0] t;
      logic [49:0] s50, t50;
      t   = (m > (63'd1 << 48)) ? (49'd1 << 48) : m[48:0];
      s50 = {{2{sum[47]}}, sum};
      t50 = {1'b0, t};
      return sat48(neg ? (s50 - t50) : (s50 + t50));
   endfunction

   // end of request: next state and result fields
   logic [49:0] cen50, spr50, sdc50, sds50, cn50, ns50;
   logic        is_calc, err;

   always_comb begin
      cen50   = {{18{center_ff[31]}}, center_ff};
      spr50   = {{18{spread_ff[31]}}, spread_ff};
      sdc50   = sumc_ff[47] ? (50'd0 - {2'b00, dc_ff[63:16]}) : {2'b00, dc_ff[63:16]};
      sds50   = sums_ff[47] ? (50'd0 - {2'b00, ds_ff[63:16]}) : {2'b00, ds_ff[63:16]};
      cn50    = cen50 - sdc50;
      ns50    = spr50 - sds50;
      is_calc = (kind_ff == REQ_EVAL) || (kind_ff == REQ_ACC);
      err     = is_calc && !spread_pos;

      center_in = center_ff;
      spread_in = spread_ff;
      sumc_in   = sumc_ff;
      sums_in   = sums_ff;
      res       = '0;

      case (kind_ff)
         REQ_EVAL: if (!err) begin
            res.membership = 17'(m_ff);
            if (d_neg_ff)
               res.grad_center = (mc_ff >= 63'h8000_0000) ? 32'h8000_0000
                                                          : 32'd0 - mc_ff[31:0];
            else
               res.grad_center = (mc_ff > 63'h7fff_ffff) ? 32'h7fff_ffff : mc_ff[31:0];
            res.grad_spread = (div_quo > 63'h7fff_ffff) ? 32'h7fff_ffff : div_quo[31:0];
         end
         REQ_ACC: if (!err) begin
            sumc_in = add48(sumc_ff, mc_ff, e_neg_ff ^ d_neg_ff);
            sums_in = add48(sums_ff, div_quo, e_neg_ff);
         end
         REQ_UPDATE: begin
            center_in = sat32(cn50);
            if (!ns50[49] && (ns50 != 50'd0)) spread_in = sat32(ns50);
            sumc_in = '0;
            sums_in = '0;
         end
         REQ_RESTORE: begin
            center_in = init_mean_ff;
            spread_in = init_width_ff;
         end
         REQ_CLEAR: begin
            sumc_in = '0;
            sums_in = '0;
         end
         default: ;
      endcase

      res.cur_center = center_in;
      res.cur_spread = spread_in;
      res.status     = err;
   end

   // configuration and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         init_mean_ff  <= 32'd0;
         init_width_ff <= 32'd65536;
         learn_rate_ff <= 16'd655;
         center_ff     <= 32'd0;
         spread_ff     <= 32'd65536;
         sumc_ff       <= '0;
         sums_ff       <= '0;
      end else begin
         if (csr_wen) begin
            unique case (csr_addr)
               CSR_INIT_MEAN:  init_mean_ff  <= csr_wdata;
               CSR_INIT_WIDTH: init_width_ff <= csr_wdata;
               CSR_LEARN_RATE: learn_rate_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.op == OP_FIN) begin
            center_ff <= center_in;
            spread_ff <= spread_in;
            sumc_ff   <= sumc_in;
            sums_ff   <= sums_in;
         end
      end
   end

   // working registers, one step per command
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            kind_ff  <= req_kind;
            d_neg_ff <= d[32];
            ad_ff    <= d[32] ? (33'd0 - d) : d;
            e_neg_ff <= error_grad[31];
            ae_ff    <= error_grad[31] ? (32'd0 - error_grad) : error_grad;
         end
         OP_PREP: begin
            ssq_ff   <= 62'(s) * 62'(s);
            eprod_ff <= 65'(ae_ff) * 65'(ad_ff);
            num_ff   <= DIV_NUM_W'(ad_ff) << F;
            den_ff   <= DIV_DEN_W'(s);
         end
         OP_SQ: begin
            rbig_ff <= div_quo >= R_LIMIT;
            rsq_ff  <= RSQ_W'(div_quo[R_W-1:0]) * RSQ_W'(div_quo[R_W-1:0]);
         end
         OP_LUT: begin
            e0_ff    <= etab[lut_idx];
            diff_ff  <= etab[lut_idx] - etab[lut_idx1];
            fr_ff    <= lut_pos[FR_W-1:0];
            mzero_ff <= lut_zero;
         end
         OP_INTERP: prod_ff <= PROD_W'(diff_ff) * PROD_W'(fr_ff);
         OP_ROUND:  m_ff <= mzero_ff ? '0 : M_W'(lut_vr >> (30 - F));
         OP_NUMC: begin
            if (kind_ff == REQ_EVAL) num_ff <= DIV_NUM_W'(mad) << F;
            else num_ff <= DIV_NUM_W'(eprod_ff) << F;
            den_ff <= ssq_ff;
         end
         OP_SPLIT: begin
            mc_ff  <= div_quo;
            plo_ff <= 65'(div_quo[31:0]) * 65'(ad_ff);
            phi_ff <= 64'(div_quo[62:32]) * 64'(ad_ff);
         end
         OP_CAT: begin
            num_ff <= {phi_ff, 32'd0} + DIV_NUM_W'(plo_ff);
            den_ff <= DIV_DEN_W'(s);
         end
         OP_UPMUL: begin
            dc_ff <= 64'(learn_rate_ff) * 64'(sumc_mag);
            ds_ff <= 64'(learn_rate_ff) * 64'(sums_mag);
         end
         default: ;
      endcase
   end

   assign stat.kind       = kind_ff;
   assign stat.spread_pos = spread_pos;
   assign div_num         = num_ff;
   assign div_den         = den_ff;

endmodule

`default_nettype wire

FILE: sv/gaussian_membership_learner_top.sv
// top level of the gaussian membership learner
`default_nettype none

// Gaussian membership unit with gradient learning in signed fixed point
// (FRAC_BITS fraction bits). Each request transfer on req_ gives exactly one
// result transfer on rsp_. Requests are handled one at a time; the next
// request is taken while a finished result still waits in the output
// register. Evaluate and accumulate use the shared radix-2 divider (one
// quotient bit per cycle over 63 bits): evaluate three times (ratio, mean
// gradient, width gradient), accumulate twice; update, restore, clear and
// a skipped request do not. Any request may wait for the output register.
// Configuration is written through csr_; the user must do so only while
// idle, which the block does not enforce. Center and width take the init
// values at reset and on restore.
module gaussian_membership_learner_top #(
   parameter int FRAC_BITS       = 16,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration write port
   input  wire logic                           csr_wen,
   input  wire logic [gml_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [31:0]                    csr_wdata,
   // request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [63:0]                    req_tdata,  // sample, error_grad
   input  wire logic [2:0]                     req_tuser,  // req_type
   // result channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // membership, grad_center, grad_spread, cur_center, cur_spread, zero pad
   output logic [151:0]                        rsp_tdata,
   output logic [0:0]                          rsp_tuser   // status
);
   import gml_pkg::*;

   cmd_type              cmd;
   stat_type             stat;
   res_type              res, rsp_res_ff;
   logic                 rsp_valid_ff;
   logic                 out_free;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_Q_W-1:0]   div_quo;
   logic                 div_done;

   // output slot can take a result when empty or emptied this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   gml_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .div_done  (div_done),
      .out_free  (out_free),
      .cmd       (cmd)
   );

   gml_dp #(
      .FRAC_BITS       (FRAC_BITS),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_kind   (req_tuser),
      .sample     (req_tdata[31:0]),
      .error_grad (req_tdata[63:32]),
      .cmd        (cmd),
      .stat       (stat),
      .div_num    (div_num),
      .div_den    (div_den),
      .div_quo    (div_quo),
      .res        (res)
   );

   // shared long divider
   gml_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   // output register, loaded when the sequencer finishes a request
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_res_ff <= res;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_res_ff.cur_spread, rsp_res_ff.cur_center,
                        rsp_res_ff.grad_spread, rsp_res_ff.grad_center,
                        rsp_res_ff.membership};
   assign rsp_tuser  = rsp_res_ff.status;

   // a request transfer always starts work, so the port closes next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request port stayed open after a transfer");

   // a skipped request carries no membership or gradients
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[80:0] == 81'd0))
      else $error("skipped request returned nonzero results");

   // a result is only written into a free output slot
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result overwrote a pending output");

endmodule

`default_nettype wire
